### rtl/pdf_pkg.sv
// Shared types and constants for the framed packet receiver with CRC-16 check.
`default_nettype none
package pdf_pkg;

	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [15:0] MAX_LEN_RESET  = 16'd256;
	localparam logic [7:0]  BYTE_START_SHORT = 8'd2;
	localparam logic [7:0]  BYTE_START_LONG  = 8'd3;
	localparam logic [7:0]  BYTE_END         = 8'd3;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEN_HI = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_DATA   = 3'd3,
		PH_CRC_HI = 3'd4,
		PH_CRC_LO = 3'd5,
		PH_END    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_START = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_BAD_END   = 3'd3,
		ST_CRC_ERR   = 3'd4
	} status_t;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] payload_index;
		logic [2:0]  status;
	} result_t;

endpackage
`default_nettype wire

### rtl/pdf_crc16.sv
// CRC-16 (poly 0x1021, MSB first) update by one byte.
`default_nettype none
module pdf_crc16 (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic [15:0]      crc_out
);
	import pdf_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

### rtl/pdf_parser.sv
// Frame parser: phase state machine, length, count and CRC registers.
`default_nettype none
module pdf_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [15:0]   max_len,
	output logic               has_result,
	output pdf_pkg::result_t   result
);
	import pdf_pkg::*;

	phase_t      phase_q, phase_d;
	logic        long_q, long_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] rcrc_q, rcrc_d;
	logic [15:0] crc_next;
	logic [15:0] cnt_inc;
	logic [15:0] len_new;

	pdf_crc16 u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	assign cnt_inc = cnt_q + 16'd1;
	assign len_new = long_q ? {len_q[15:8], rx_byte} : {8'h00, rx_byte};

	always_comb begin
		phase_d = phase_q;
		long_d  = long_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		crc_d   = crc_q;
		rcrc_d  = rcrc_q;
		case (phase_q)
			PH_LEN_HI: begin
				len_d   = {rx_byte, 8'h00};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d = len_new;
				if (len_new > max_len) begin
					phase_d = PH_IDLE;
				end else begin
					crc_d   = 16'h0000;
					cnt_d   = 16'h0000;
					phase_d = (len_new == 16'h0000) ? PH_CRC_HI : PH_DATA;
				end
			end
			PH_DATA: begin
				crc_d = crc_next;
				cnt_d = cnt_inc;
				if (cnt_inc == len_q) begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				rcrc_d  = {rx_byte, 8'h00};
				phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				rcrc_d  = {rcrc_q[15:8], rx_byte};
				phase_d = PH_END;
			end
			PH_END: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
				if (rx_byte == BYTE_START_SHORT) begin
					long_d  = 1'b0;
					phase_d = PH_LEN_LO;
				end else if (rx_byte == BYTE_START_LONG) begin
					long_d  = 1'b1;
					phase_d = PH_LEN_HI;
				end
			end
		endcase
	end

	always_comb begin
		has_result           = 1'b0;
		result.kind          = KIND_STATUS;
		result.data_byte     = 8'h00;
		result.payload_index = len_q;
		result.status        = ST_OK;
		case (phase_q)
			PH_LEN_HI, PH_CRC_HI, PH_CRC_LO: begin
				has_result = 1'b0;
			end
			PH_LEN_LO: begin
				has_result           = (len_new > max_len);
				result.payload_index = len_new;
				result.status        = ST_TOO_LONG;
			end
			PH_DATA: begin
				has_result           = 1'b1;
				result.kind          = KIND_DATA;
				result.data_byte     = rx_byte;
				result.payload_index = cnt_q;
			end
			PH_END: begin
				has_result = 1'b1;
				if (rx_byte != BYTE_END) begin
					result.status = ST_BAD_END;
				end else if (rcrc_q != crc_q) begin
					result.status = ST_CRC_ERR;
				end else begin
					result.status = ST_OK;
				end
			end
			default: begin
				has_result           = (rx_byte != BYTE_START_SHORT) &&
				                       (rx_byte != BYTE_START_LONG);
				result.payload_index = 16'h0000;
				result.status        = ST_BAD_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			long_q  <= 1'b0;
			len_q   <= 16'h0000;
			cnt_q   <= 16'h0000;
			crc_q   <= 16'h0000;
			rcrc_q  <= 16'h0000;
		end else if (go) begin
			phase_q <= phase_d;
			long_q  <= long_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			rcrc_q  <= rcrc_d;
		end
	end

endmodule
`default_nettype wire

### rtl/packet_deframer_crc16_unit.sv
// Top level: input register, frame parser, result register and length limit register.
// A byte is held in the input register and its result in the result register driving out_valid.
// Throughput: one byte per cycle while not stalled; phase steps per byte, CRC per payload byte.
// in_stall rises only while a byte that makes a result waits on a full, stalled result register.
// Reset (arst_n low, asynchronous): pipeline empty, parser idle, counters and CRC zero,
// max_payload_length 256.
`default_nettype none
module packet_deframer_crc16_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [7:0]       data_byte,
	output logic [15:0]      payload_index,
	output logic [2:0]       status,
	input  wire logic        cfg_write,
	input  wire logic [15:0] cfg_data
);
	import pdf_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic [15:0] max_len_q;
	logic        out_free;
	logic        go;
	logic        has_result;
	result_t     result;

	assign out_free = !valid_s2 || !out_stall;
	assign go       = valid_s1 && (!has_result || out_free);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_write) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	pdf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.rx_byte    (byte_s1),
		.max_len    (max_len_q),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= go && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go && has_result) begin
			res_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = res_s2.kind;
	assign data_byte     = res_s2.data_byte;
	assign payload_index = res_s2.payload_index;
	assign status        = res_s2.status;

endmodule
`default_nettype wire
